>>> hdl/dbd_pkg.sv
// Shared constants, codes and types for the Donchian breakout detector.
package dbd_pkg;

    localparam int MAX_PERIOD_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;

    localparam int WIN_REG_W  = 7;
    localparam int CFG_ADDR_W = 1;

    localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 7'd20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_UPPER_WINDOW = 1'b0,
        REG_LOWER_WINDOW = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BRK_NONE  = 2'd0,
        BRK_ABOVE = 2'd1,
        BRK_BELOW = 2'd2
    } breakout_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_HOLD
    } dbd_state_t;

endpackage

>>> hdl/dbd_cell.sv
// One history cell: holds a past bar and folds it into the passing max/min token.
module dbd_cell #(
    parameter int PRICE_BITS = 32,
    parameter int WIN_W      = 7,
    parameter int BACK       = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  shift_en,
    input  logic [PRICE_BITS-1:0] hist_hi_in,
    input  logic [PRICE_BITS-1:0] hist_lo_in,
    output logic [PRICE_BITS-1:0] hist_hi_out,
    output logic [PRICE_BITS-1:0] hist_lo_out,
    input  logic [WIN_W-1:0]      upper_win,
    input  logic [WIN_W-1:0]      lower_win,
    input  logic                  tok_in,
    input  logic [PRICE_BITS-1:0] acc_hi_in,
    input  logic [PRICE_BITS-1:0] acc_lo_in,
    output logic                  tok_out,
    output logic [PRICE_BITS-1:0] acc_hi_out,
    output logic [PRICE_BITS-1:0] acc_lo_out
);

    // how many bars back this cell sits
    localparam logic [WIN_W-1:0] BACK_POS = WIN_W'(BACK);

    logic [PRICE_BITS-1:0] hist_hi_reg;
    logic [PRICE_BITS-1:0] hist_lo_reg;
    logic [PRICE_BITS-1:0] acc_hi_reg, acc_hi_next;
    logic [PRICE_BITS-1:0] acc_lo_reg, acc_lo_next;
    logic                  tok_reg;

    always_comb begin
        acc_hi_next = acc_hi_in;
        acc_lo_next = acc_lo_in;
        if ((BACK_POS <= upper_win) && (hist_hi_reg > acc_hi_in)) begin
            acc_hi_next = hist_hi_reg;
        end
        if ((BACK_POS <= lower_win) && (hist_lo_reg < acc_lo_in)) begin
            acc_lo_next = hist_lo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            hist_hi_reg <= hist_hi_in;
            hist_lo_reg <= hist_lo_in;
        end
        if (tok_in) begin
            acc_hi_reg <= acc_hi_next;
            acc_lo_reg <= acc_lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
        end else begin
            tok_reg <= tok_in;
        end
    end

    assign hist_hi_out = hist_hi_reg;
    assign hist_lo_out = hist_lo_reg;
    assign tok_out     = tok_reg;
    assign acc_hi_out  = acc_hi_reg;
    assign acc_lo_out  = acc_lo_reg;

endmodule

>>> hdl/donchian_breakout_detector.sv
// Top level: Donchian channel breakout detector built on a chain of history cells.
// The result word is loaded once the token has left the end of the chain and the output is free;
//   a new bar is taken only after that load. A max/min token walks the whole
//   MAX_PERIOD-cell chain, one cell per cycle, before the history can shift.
// Reset (aresetn, synchronous, active low): idle, no result pending, bar count zero,
//   both windows back to 20. History cells are not cleared; they fill as bars arrive.
module donchian_breakout_detector
    import dbd_pkg::*;
#(
    parameter int MAX_PERIOD = MAX_PERIOD_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    localparam int IN_W  = ((3 * PRICE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * PRICE_BITS + 3 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // bar words in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // bar_high, bar_low, bar_close (low bit up)
    // result words out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // channel_valid, upper_edge, lower_edge, breakout
    // register writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WIN_REG_W-1:0]  cfg_wr_data
);

    localparam int WIN_W = $clog2(MAX_PERIOD + 1);
    localparam int CMP_W = (WIN_W > WIN_REG_W) ? WIN_W : WIN_REG_W;
    localparam int PAD_W = OUT_W - (2 * PRICE_BITS + 3);

    typedef logic [PRICE_BITS-1:0] price_t;

    // ---------------- configuration ----------------
    logic [WIN_REG_W-1:0] upper_window_reg;
    logic [WIN_REG_W-1:0] lower_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_window_reg <= WINDOW_RESET;
            lower_window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_UPPER_WINDOW: upper_window_reg <= cfg_wr_data;
                REG_LOWER_WINDOW: lower_window_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, anything past the chain length saturates
    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_REG_W-1:0] w);
        logic [WIN_W-1:0] r;
        if (w == '0) begin
            r = WIN_W'(1);
        end else if (CMP_W'(w) > CMP_W'(MAX_PERIOD)) begin
            r = WIN_W'(MAX_PERIOD);
        end else begin
            r = WIN_W'(w);
        end
        return r;
    endfunction

    logic [WIN_W-1:0] upper_win;
    logic [WIN_W-1:0] lower_win;
    logic [WIN_W-1:0] need_bars;

    assign upper_win = eff_window(upper_window_reg);
    assign lower_win = eff_window(lower_window_reg);
    assign need_bars = (upper_win > lower_win) ? upper_win : lower_win;

    // ---------------- control ----------------
    dbd_state_t state_reg, state_next;

    logic in_fire;
    logic out_free;
    logic sweep_done;
    logic load_out;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (sweep_done) state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SWEEP: load_out = sweep_done && out_free;
            ST_HOLD:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- bar capture ----------------
    price_t bar_high_reg;
    price_t bar_low_reg;
    price_t bar_close_reg;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            bar_high_reg  <= s_tdata[PRICE_BITS-1:0];
            bar_low_reg   <= s_tdata[2*PRICE_BITS-1:PRICE_BITS];
            bar_close_reg <= s_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
        end
    end

    // ---------------- cell chain ----------------
    // Token enters cell 0 on accept with max/min identities and gathers one
    // cell per cycle. History shifts only when the result is loaded, so the
    // sweep always sees the bars before the current one.
    price_t hist_hi [0:MAX_PERIOD];
    price_t hist_lo [0:MAX_PERIOD];
    price_t acc_hi  [0:MAX_PERIOD];
    price_t acc_lo  [0:MAX_PERIOD];
    logic   tok     [0:MAX_PERIOD];

    assign hist_hi[0] = bar_high_reg;
    assign hist_lo[0] = bar_low_reg;
    assign tok[0]     = in_fire;
    assign acc_hi[0]  = '0;
    assign acc_lo[0]  = '1;

    for (genvar i = 0; i < MAX_PERIOD; i++) begin : g_cell
        dbd_cell #(
            .PRICE_BITS(PRICE_BITS),
            .WIN_W     (WIN_W),
            .BACK      (i + 1)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (load_out),
            .hist_hi_in (hist_hi[i]),
            .hist_lo_in (hist_lo[i]),
            .hist_hi_out(hist_hi[i+1]),
            .hist_lo_out(hist_lo[i+1]),
            .upper_win  (upper_win),
            .lower_win  (lower_win),
            .tok_in     (tok[i]),
            .acc_hi_in  (acc_hi[i]),
            .acc_lo_in  (acc_lo[i]),
            .tok_out    (tok[i+1]),
            .acc_hi_out (acc_hi[i+1]),
            .acc_lo_out (acc_lo[i+1])
        );
    end

    // tail accumulators hold until the next token, so HOLD can wait on them
    assign sweep_done = tok[MAX_PERIOD];

    // ---------------- bar count ----------------
    logic [WIN_W-1:0] bars_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bars_seen_reg <= '0;
        end else if (load_out && (bars_seen_reg != WIN_W'(MAX_PERIOD))) begin
            bars_seen_reg <= bars_seen_reg + WIN_W'(1);
        end
    end

    // ---------------- result ----------------
    logic      res_valid;
    price_t    res_upper;
    price_t    res_lower;
    breakout_t res_brk;

    always_comb begin
        res_valid = (bars_seen_reg >= need_bars);
        res_upper = '0;
        res_lower = '0;
        res_brk   = BRK_NONE;
        if (res_valid) begin
            res_upper = acc_hi[MAX_PERIOD];
            res_lower = acc_lo[MAX_PERIOD];
            if (bar_close_reg > acc_hi[MAX_PERIOD]) begin
                res_brk = BRK_ABOVE;
            end else if (bar_close_reg < acc_lo[MAX_PERIOD]) begin
                res_brk = BRK_BELOW;
            end
        end
    end

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, res_brk, res_lower, res_upper, res_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hdl/dbd_checker.sv
// Port-level checks for the Donchian breakout detector, bound to the top level.
module dbd_checker
    import dbd_pkg::*;
#(
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int IN_W       = 96,
    parameter int OUT_W      = 72
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_W-1:0]       s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_W-1:0]      m_tdata,
    input logic                  cfg_wr_en,
    input logic [CFG_ADDR_W-1:0] cfg_addr,
    input logic [WIN_REG_W-1:0]  cfg_wr_data
);

    logic                  chan_valid;
    logic [PRICE_BITS-1:0] upper_edge;
    logic [PRICE_BITS-1:0] lower_edge;
    logic [1:0]            brk;
    logic                  cfg_seen;

    assign chan_valid = m_tdata[0];
    assign upper_edge = m_tdata[PRICE_BITS:1];
    assign lower_edge = m_tdata[2*PRICE_BITS:PRICE_BITS+1];
    assign brk        = m_tdata[2*PRICE_BITS+2:2*PRICE_BITS+1];
    assign cfg_seen   = cfg_wr_en && (cfg_addr == cfg_addr) && (cfg_wr_data == cfg_wr_data)
                        && (s_tdata == s_tdata);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one bar at a time: accepting a bar closes the input
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready right after accepting a bar");

    // invalid channel carries zero edges and no signal
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !chan_valid |->
            (upper_edge == '0) && (lower_edge == '0) && (brk == BRK_NONE))
        else $error("invalid channel with nonzero fields");

    // breakout code is one of the defined codes
    a_brk_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (brk == BRK_NONE) || (brk == BRK_ABOVE) || (brk == BRK_BELOW))
        else $error("undefined breakout code");

    // a register write never produces a result by itself
    a_cfg_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_seen && !m_tvalid && s_tready |=> !m_tvalid)
        else $error("result appeared after a register write while idle");

endmodule

bind donchian_breakout_detector dbd_checker #(
    .PRICE_BITS(PRICE_BITS),
    .IN_W      (IN_W),
    .OUT_W     (OUT_W)
) u_dbd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data)
);
